>>> rtl/core/alu_with_barrel_shifter_and_flags_top_assert.svh
// Assertion macros for the data-processing execute block.
// Used by alu_with_barrel_shifter_and_flags_top; expects clk and arst_n in scope.
`ifndef ALU_WITH_BARREL_SHIFTER_AND_FLAGS_TOP_ASSERT_SVH
`define ALU_WITH_BARREL_SHIFTER_AND_FLAGS_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Check that a condition holds at every clock edge out of reset
`define ABF_ASSERT_ALWAYS(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("abf: invariant check failed");
// Check that a trigger in one cycle implies a condition in the next
`define ABF_ASSERT_NEXT(name, trig, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("abf: next-cycle check failed");
`else
`define ABF_ASSERT_ALWAYS(name, cond)
`define ABF_ASSERT_NEXT(name, trig, cond)
`endif

`endif

>>> rtl/core/abf_pkg.sv
// Shared types and constants for the data-processing execute block.
// No dependencies; used by abf_shifter, abf_alu and the top level.
package abf_pkg;

	localparam int unsigned DataW = 32;

	// Data operation codes
	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_SUB = 4'd2,
		OP_RSB = 4'd3,
		OP_ADD = 4'd4,
		OP_ADC = 4'd5,
		OP_SBC = 4'd6,
		OP_RSC = 4'd7,
		OP_TST = 4'd8,
		OP_TEQ = 4'd9,
		OP_CMP = 4'd10,
		OP_CMN = 4'd11,
		OP_ORR = 4'd12,
		OP_MOV = 4'd13,
		OP_BIC = 4'd14,
		OP_MVN = 4'd15
	} op_t;

	// Register shift kinds
	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} shift_t;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} flags_t;

	typedef struct packed {
		logic [DataW-1:0] value;
		logic             carry;
	} shift_out_t;

	typedef struct packed {
		logic [DataW-1:0] result;
		logic             write_back;
		flags_t           flags;
	} alu_out_t;

endpackage

>>> rtl/core/abf_shifter.sv
// Second-operand barrel shifter: rotated immediate or shifted register, with carry out.
// Depends on abf_pkg.
module abf_shifter (
	input  logic                     is_immediate,
	input  logic [11:0]              operand_field,
	input  logic [31:0]              shifted_value,
	input  logic [7:0]               shift_reg_amount,
	input  logic                     carry_in,
	output abf_pkg::shift_out_t      shift_out
);
	import abf_pkg::*;

	logic [4:0]         rot;
	logic [63:0]        imm_w;
	logic [7:0]         amt;
	shift_t             kind;
	logic               sign;
	logic               amt_big;
	logic               amt_32;
	logic [32:0]        lsl_w;
	logic [32:0]        lsr_w;
	logic signed [32:0] asr_w;
	logic [63:0]        ror_w;

	// Form every shift candidate in parallel
	always_comb begin
		rot     = {operand_field[11:8], 1'b0};
		imm_w   = {24'd0, operand_field[7:0], 24'd0, operand_field[7:0]} >> rot;
		kind    = shift_t'(operand_field[6:5]);
		sign    = shifted_value[31];
		amt     = operand_field[4] ? shift_reg_amount : {3'd0, operand_field[11:7]};
		amt_big = (amt[7:5] != 3'd0);
		amt_32  = (amt == 8'd32);
		lsl_w   = {1'b0, shifted_value} << amt[4:0];
		lsr_w   = {shifted_value, 1'b0} >> amt[4:0];
		asr_w   = $signed({shifted_value, 1'b0}) >>> amt[4:0];
		ror_w   = {shifted_value, shifted_value} >> amt[4:0];
	end

	// Select the operand and its carry
	always_comb begin
		shift_out.value = shifted_value;
		shift_out.carry = carry_in;
		if (is_immediate) begin
			shift_out.value = imm_w[31:0];
			shift_out.carry = (rot == 5'd0) ? carry_in : imm_w[31];
		end else if (amt == 8'd0) begin
			if (!operand_field[4]) begin
				// immediate amount zero: LSR/ASR mean 32, ROR means RRX
				case (kind)
					SH_LSL: begin
						shift_out.value = shifted_value;
						shift_out.carry = carry_in;
					end
					SH_LSR: begin
						shift_out.value = '0;
						shift_out.carry = sign;
					end
					SH_ASR: begin
						shift_out.value = {DataW{sign}};
						shift_out.carry = sign;
					end
					SH_ROR: begin
						shift_out.value = {carry_in, shifted_value[31:1]};
						shift_out.carry = shifted_value[0];
					end
					default: begin
						shift_out.value = shifted_value;
						shift_out.carry = carry_in;
					end
				endcase
			end
		end else begin
			case (kind)
				SH_LSL: begin
					if (amt_big) begin
						shift_out.value = '0;
						shift_out.carry = amt_32 & shifted_value[0];
					end else begin
						shift_out.value = lsl_w[31:0];
						shift_out.carry = lsl_w[32];
					end
				end
				SH_LSR: begin
					if (amt_big) begin
						shift_out.value = '0;
						shift_out.carry = amt_32 & sign;
					end else begin
						shift_out.value = lsr_w[32:1];
						shift_out.carry = lsr_w[0];
					end
				end
				SH_ASR: begin
					if (amt_big) begin
						shift_out.value = {DataW{sign}};
						shift_out.carry = sign;
					end else begin
						shift_out.value = asr_w[32:1];
						shift_out.carry = asr_w[0];
					end
				end
				SH_ROR: begin
					// whole turns pass the value with carry from the sign
					if (amt[4:0] == 5'd0) begin
						shift_out.value = shifted_value;
						shift_out.carry = sign;
					end else begin
						shift_out.value = ror_w[31:0];
						shift_out.carry = ror_w[31];
					end
				end
				default: begin
					shift_out.value = shifted_value;
					shift_out.carry = carry_in;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/abf_alu.sv
// Data-operation ALU: 16 operations, write-back enable and next NZCV flags.
// Depends on abf_pkg; operand two comes from abf_shifter.
module abf_alu (
	input  abf_pkg::op_t         opcode,
	input  logic                 set_flags,
	input  logic [11:0]          operand_field,
	input  logic [3:0]           first_reg_field,
	input  logic [31:0]          first_value,
	input  abf_pkg::shift_out_t  operand_b,
	input  abf_pkg::flags_t      flags_in,
	output abf_pkg::alu_out_t    alu_out
);
	import abf_pkg::*;

	logic [DataW-1:0] add_x;
	logic [DataW-1:0] add_y;
	logic             add_ci;
	logic [DataW:0]   sum;
	logic             add_v;
	logic             logical;
	logic [DataW-1:0] res;
	logic             wb;
	logic [DataW-1:0] a;
	logic [DataW-1:0] b;

	// Pick adder operands and carry in
	always_comb begin
		a      = first_value;
		b      = operand_b.value;
		add_x  = a;
		add_y  = b;
		add_ci = 1'b0;
		case (opcode)
			OP_SUB, OP_CMP: begin
				add_y  = ~b;
				add_ci = 1'b1;
			end
			OP_RSB: begin
				add_x  = b;
				add_y  = ~a;
				add_ci = 1'b1;
			end
			OP_ADC: add_ci = flags_in.c;
			OP_SBC: begin
				add_y  = ~b;
				add_ci = flags_in.c;
			end
			OP_RSC: begin
				add_x  = b;
				add_y  = ~a;
				add_ci = flags_in.c;
			end
			default: begin
				add_x  = a;
				add_y  = b;
				add_ci = 1'b0;
			end
		endcase
		sum   = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_ci};
		add_v = ~(add_x[DataW-1] ^ add_y[DataW-1]) & (add_x[DataW-1] ^ sum[DataW-1]);
	end

	// Select the result and write-back
	always_comb begin
		logical = 1'b1;
		wb      = 1'b1;
		res     = sum[DataW-1:0];
		case (opcode)
			OP_AND: res = a & b;
			OP_EOR: res = a ^ b;
			OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC: logical = 1'b0;
			OP_TST: begin
				if (set_flags) begin
					res = a & b;
					wb  = 1'b0;
				end else begin
					// tst without S loads a 16-bit immediate
					res = {16'd0, first_reg_field, operand_field};
				end
			end
			OP_TEQ: begin
				res = a ^ b;
				wb  = 1'b0;
			end
			OP_CMP, OP_CMN: begin
				logical = 1'b0;
				wb      = 1'b0;
			end
			OP_ORR: res = a | b;
			OP_MOV: res = b;
			OP_BIC: res = a & ~b;
			OP_MVN: res = ~b;
			default: res = ~b;
		endcase
	end

	// Build next flags; hold them unless S is set
	always_comb begin
		alu_out.result     = res;
		alu_out.write_back = wb;
		alu_out.flags      = flags_in;
		if (set_flags) begin
			alu_out.flags.n = res[DataW-1];
			alu_out.flags.z = (res == '0);
			alu_out.flags.c = logical ? operand_b.carry : sum[DataW];
			alu_out.flags.v = logical ? flags_in.v : add_v;
		end
	end

endmodule

>>> rtl/core/alu_with_barrel_shifter_and_flags_top.sv
// Top level of the data-processing execute block: input register, shifter, ALU,
// result register and stored NZCV. Depends on abf_pkg, abf_shifter, abf_alu.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------------
//  s       | in  | s_tvalid/s_tready | s_tdata (operation request), s_tuser
//  m       | out | m_tvalid/m_tready | m_tdata (result, write-back, flags)
//
// One request per cycle is sustained while m_tready is high. An accepted request
// waits in the input register; m_tvalid rises once it moves into the result
// register. The stored flags update as a request moves into the result register,
// so the next request sees them at once. Reset clears both valid bits and the
// flags. A stalled output holds the result register and the input register;
// s_tready drops only when both are full.
module alu_with_barrel_shifter_and_flags_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] opcode, [4] set_flags, [16:5] operand_field, [20:17] first_reg_field,
	// [52:21] first_value, [84:53] shifted_value, [92:85] shift_reg_amount, rest zero
	input  logic [95:0] s_tdata,
	// [0] is_immediate
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] result, [32] write_back, [33] flag_n, [34] flag_z, [35] flag_c,
	// [36] flag_v, rest zero
	output logic [39:0] m_tdata
);
	import abf_pkg::*;

	`include "alu_with_barrel_shifter_and_flags_top_assert.svh"

	logic        valid_s1;
	op_t         opcode_s1;
	logic        set_flags_s1;
	logic        is_immediate_s1;
	logic [11:0] operand_field_s1;
	logic [3:0]  first_reg_field_s1;
	logic [31:0] first_value_s1;
	logic [31:0] shifted_value_s1;
	logic [7:0]  shift_reg_amount_s1;

	logic        valid_s2;
	alu_out_t    out_s2;

	flags_t      flags_q;
	shift_out_t  shift_out;
	alu_out_t    alu_out;
	logic        advance;
	logic        s_take;

	// Move the held request on when the result register is free or draining
	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign s_take   = s_tvalid & s_tready;

	// Valid bits and stored flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance) begin
				valid_s2 <= 1'b1;
				flags_q  <= alu_out.flags;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (s_take) begin
			opcode_s1           <= op_t'(s_tdata[3:0]);
			set_flags_s1        <= s_tdata[4];
			operand_field_s1    <= s_tdata[16:5];
			first_reg_field_s1  <= s_tdata[20:17];
			first_value_s1      <= s_tdata[52:21];
			shifted_value_s1    <= s_tdata[84:53];
			shift_reg_amount_s1 <= s_tdata[92:85];
			is_immediate_s1     <= s_tuser;
		end
	end

	abf_shifter u_shifter (
		.is_immediate     (is_immediate_s1),
		.operand_field    (operand_field_s1),
		.shifted_value    (shifted_value_s1),
		.shift_reg_amount (shift_reg_amount_s1),
		.carry_in         (flags_q.c),
		.shift_out        (shift_out)
	);

	abf_alu u_alu (
		.opcode          (opcode_s1),
		.set_flags       (set_flags_s1),
		.operand_field   (operand_field_s1),
		.first_reg_field (first_reg_field_s1),
		.first_value     (first_value_s1),
		.operand_b       (shift_out),
		.flags_in        (flags_q),
		.alu_out         (alu_out)
	);

	// Load the result register
	always_ff @(posedge clk) begin
		if (advance)
			out_s2 <= alu_out;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, out_s2.flags.v, out_s2.flags.c, out_s2.flags.z,
		out_s2.flags.n, out_s2.write_back, out_s2.result};

	// Flags change only when a request moves into the result register
	`ABF_ASSERT_NEXT(a_flags_hold_idle, !advance, $stable(flags_q))
	// A request without S leaves the flags alone
	`ABF_ASSERT_NEXT(a_flags_hold_no_s, advance && !set_flags_s1, $stable(flags_q))
	// A waiting result always shows the flags currently stored
	`ABF_ASSERT_ALWAYS(a_out_flags_match, !valid_s2 || (out_s2.flags == flags_q))

endmodule
